[src/vpsc_pkg.sv]
// ----------------------------------------------------------------------------
// vpsc_pkg
// Shared types, codes and defaults of the value profile site counter.
// ----------------------------------------------------------------------------
package vpsc_pkg;

	localparam int unsigned DefSites        = 1024;
	localparam int unsigned DefSlotsPerSite = 8;
	localparam int unsigned DefPoolNodes    = 8192;

	localparam logic [63:0] MemopSmall = 64'd8;
	localparam logic [63:0] MemopLast  = 64'd513;
	localparam logic [63:0] SignMin    = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_PLAIN = 2'd0,
		OP_RANGE = 2'd1,
		OP_MEMOP = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_NEW      = 3'd1,
		ST_REPLACED = 3'd2,
		ST_DECR     = 3'd3,
		ST_POOLFULL = 3'd4,
		ST_IGNORED  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MAP1,
		S_MAP2,
		S_FILL,
		S_RD,
		S_CMP,
		S_DECIDE,
		S_OUT
	} state_t;

	// write enables toward the slot store
	typedef struct packed {
		logic val_we;
		logic cnt_we;
		logic fill_we;
	} store_we_t;

endpackage

[src/value_profile_site_counter.sv]
// ----------------------------------------------------------------------------
// value_profile_site_counter
// Per-site top-k value counter with a shared slot pool.
// ----------------------------------------------------------------------------
// Input beats carry a site, an opcode and a value with its range bounds; each
// beat yields exactly one output beat with a status, the mapped value and the
// touched slot count. Both channels use valid and stall.
// After reset a clearing pass writes every site's fill count to zero, during
// which in_stall is high.
// A beat then passes the mapping states S_MAP1 and S_MAP2, the fill lookup
// S_FILL, a read S_RD and a compare S_CMP per scanned slot plus one closing
// read, the update S_DECIDE and the output state S_OUT. A hit ends the scan
// at S_CMP, which writes the count, and an ignored beat goes from S_MAP2
// straight to S_OUT. The slots are walked one at a time through the single
// slot memory read port and the one compare unit.
// One beat is in flight at a time. A finished result sits in the output
// register; while out_stall holds it, a new beat is accepted and processed,
// and it waits at the output until the held beat leaves.
// Reset clears the control state; the memories are covered by the fill count.
// ----------------------------------------------------------------------------
module value_profile_site_counter #(
	parameter int unsigned SITES          = vpsc_pkg::DefSites,
	parameter int unsigned SLOTS_PER_SITE = vpsc_pkg::DefSlotsPerSite,
	parameter int unsigned POOL_NODES     = vpsc_pkg::DefPoolNodes
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [9:0]         site,
	input  logic               has_value_table,
	input  logic [63:0]        obs_value,
	input  logic signed [63:0] range_start,
	input  logic signed [63:0] range_last,
	input  logic signed [63:0] large_threshold,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [63:0]        recorded_value,
	output logic [63:0]        entry_count
);
	import vpsc_pkg::*;

	localparam int unsigned Entries = SITES * SLOTS_PER_SITE;
	localparam int unsigned EntW  = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int unsigned SiteW = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int unsigned KW    = $clog2(SLOTS_PER_SITE + 1);
	localparam int unsigned PoolW = $clog2(POOL_NODES);
	localparam int unsigned ExtW  = 17;

	state_t state_q, state_d;

	// input beat
	logic [1:0]         opcode_q;
	logic [9:0]         site_q;
	logic               table_q;
	logic [63:0]        value_q;
	logic signed [63:0] start_q;
	logic signed [63:0] last_q;
	logic signed [63:0] large_q;

	// work registers
	logic [63:0]      mval_q;
	logic [EntW-1:0]  base_q;
	logic [KW-1:0]    fill_q;
	logic [KW-1:0]    k_q;
	logic [KW-1:0]    min_k_q;
	logic [63:0]      min_cnt_q;
	logic [PoolW-1:0] pool_q;
	logic [SiteW-1:0] clr_q;
	logic [2:0]       res_status_q;
	logic [63:0]      res_count_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [63:0] recorded_q;
	logic [63:0] count_q;

	logic [63:0]      mapped;
	logic [ExtW-1:0]  site_ext;
	logic [SiteW-1:0] site_idx;
	logic             site_ok;
	logic             full;
	logic [63:0]      dec_cnt;
	logic [KW-1:0]    sel_k;

	store_we_t        we;
	logic [EntW-1:0]  slot_addr;
	logic [63:0]      wr_value;
	logic [63:0]      wr_count;
	logic [63:0]      rd_value;
	logic [63:0]      rd_count;
	logic [SiteW-1:0] fill_addr;
	logic [KW-1:0]    fill_wdata;
	logic [KW-1:0]    fill_rdata;
	logic             out_load;

	assign site_ext = ExtW'(site_q);
	assign site_idx = site_ext[SiteW-1:0];
	assign site_ok  = table_q && (32'(site_q) < 32'(SITES));
	assign full     = (fill_q == KW'(SLOTS_PER_SITE));
	assign dec_cnt  = (min_cnt_q != 64'd0) ? (min_cnt_q - 64'd1) : 64'd0;
	assign sel_k    = (state_q == S_DECIDE) ? (full ? min_k_q : fill_q) : k_q;
	assign slot_addr = base_q + EntW'(sel_k);
	assign fill_addr = (state_q == S_CLEAR) ? clr_q : site_idx;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	vpsc_mapper u_mapper (
		.clk             (clk),
		.step1           (state_q == S_MAP1),
		.opcode          (opcode_q),
		.value           (value_q),
		.range_start     (start_q),
		.range_last      (last_q),
		.large_threshold (large_q),
		.mapped          (mapped)
	);

	vpsc_store #(
		.SITES          (SITES),
		.SLOTS_PER_SITE (SLOTS_PER_SITE)
	) u_store (
		.clk        (clk),
		.we         (we),
		.slot_addr  (slot_addr),
		.wr_value   (wr_value),
		.wr_count   (wr_count),
		.rd_value   (rd_value),
		.rd_count   (rd_count),
		.fill_addr  (fill_addr),
		.fill_wdata (fill_wdata),
		.fill_rdata (fill_rdata)
	);

	// next state and store writes
	always_comb begin
		state_d    = state_q;
		we         = '0;
		wr_value   = mval_q;
		wr_count   = 64'd1;
		fill_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				we.fill_we = 1'b1;
				if (clr_q == SiteW'(SITES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_MAP1;
				end
			end
			S_MAP1: state_d = S_MAP2;
			S_MAP2: state_d = site_ok ? S_FILL : S_OUT;
			S_FILL: state_d = S_RD;
			S_RD: begin
				state_d = (k_q == fill_q) ? S_DECIDE : S_CMP;
			end
			S_CMP: begin
				if (rd_value == mval_q) begin
					we.cnt_we = 1'b1;
					wr_count  = rd_count + 64'd1;
					state_d   = S_OUT;
				end else begin
					state_d = S_RD;
				end
			end
			S_DECIDE: begin
				state_d = S_OUT;
				if (full) begin
					we.cnt_we = 1'b1;
					if (dec_cnt == 64'd0) begin
						we.val_we = 1'b1;
					end else begin
						wr_count = dec_cnt;
					end
				end else if (32'(pool_q) < 32'(POOL_NODES - 1)) begin
					we.val_we  = 1'b1;
					we.cnt_we  = 1'b1;
					we.fill_we = 1'b1;
					fill_wdata = fill_q + KW'(1);
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pool_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + SiteW'(1);
			end
			if (state_q == S_DECIDE && we.fill_we) begin
				pool_q <= pool_q + PoolW'(1);
			end
		end
	end

	// capture the input beat
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			opcode_q <= opcode;
			site_q   <= site;
			table_q  <= has_value_table;
			value_q  <= obs_value;
			start_q  <= range_start;
			last_q   <= range_last;
			large_q  <= large_threshold;
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_MAP1: begin
				base_q <= EntW'(site_idx) * EntW'(SLOTS_PER_SITE);
			end
			S_MAP2: begin
				mval_q       <= mapped;
				res_status_q <= ST_IGNORED;
				res_count_q  <= 64'd0;
			end
			S_FILL: begin
				fill_q    <= fill_rdata;
				k_q       <= '0;
				min_k_q   <= '0;
				min_cnt_q <= '1;
			end
			S_CMP: begin
				if (rd_value == mval_q) begin
					res_status_q <= ST_HIT;
					res_count_q  <= rd_count + 64'd1;
				end else begin
					if (rd_count < min_cnt_q) begin
						min_cnt_q <= rd_count;
						min_k_q   <= k_q;
					end
					k_q <= k_q + KW'(1);
				end
			end
			S_DECIDE: begin
				if (full) begin
					if (dec_cnt == 64'd0) begin
						res_status_q <= ST_REPLACED;
						res_count_q  <= 64'd1;
					end else begin
						res_status_q <= ST_DECR;
						res_count_q  <= dec_cnt;
					end
				end else if (we.fill_we) begin
					res_status_q <= ST_NEW;
					res_count_q  <= 64'd1;
				end else begin
					res_status_q <= ST_POOLFULL;
				end
			end
			default: ;
		endcase
	end

	// output register: hold while stalled, advance otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q   <= res_status_q;
			recorded_q <= mval_q;
			count_q    <= res_count_q;
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign recorded_value = recorded_q;
	assign entry_count    = count_q;

endmodule

[src/vpsc_mapper.sv]
// ----------------------------------------------------------------------------
// vpsc_mapper
// Two-step value mapping: plain, range clamp or memop size bucket.
// ----------------------------------------------------------------------------
module vpsc_mapper (
	input  logic               clk,
	input  logic               step1,
	input  logic [1:0]         opcode,
	input  logic [63:0]        value,
	input  logic signed [63:0] range_start,
	input  logic signed [63:0] range_last,
	input  logic signed [63:0] large_threshold,
	output logic [63:0]        mapped
);
	import vpsc_pkg::*;

	logic       large_hit_q;
	logic       below_start_q;
	logic       above_last;
	logic [3:0] top;
	logic [9:0] low;
	logic [63:0] range_val;
	logic [63:0] memop_val;

	// step one: clamp and lower bound compares
	always_ff @(posedge clk) begin
		if (step1) begin
			large_hit_q   <= (large_threshold != $signed(SignMin)) &&
				!($signed(value) < large_threshold);
			below_start_q <= $signed(value) < range_start;
		end
	end

	// step two: upper bound compare and final select
	always_comb begin
		above_last = range_last < $signed(value);
		if (large_hit_q) begin
			range_val = large_threshold;
		end else if (below_start_q || above_last) begin
			range_val = range_last + 64'sd1;
		end else begin
			range_val = value;
		end
	end

	// bucket memop sizes by leading one of the low bits
	always_comb begin
		low = value[9:0];
		top = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (low[i]) begin
				top = 4'(i);
			end
		end
		if (value <= MemopSmall) begin
			memop_val = value;
		end else if (value >= MemopLast) begin
			memop_val = MemopLast;
		end else if ((low & (low - 10'd1)) == 10'd0) begin
			memop_val = value;
		end else begin
			memop_val = (64'd1 << top) + 64'd1;
		end
	end

	always_comb begin
		case (opcode)
			OP_RANGE: mapped = range_val;
			OP_MEMOP: mapped = memop_val;
			default:  mapped = value;
		endcase
	end

endmodule

[src/vpsc_store.sv]
// ----------------------------------------------------------------------------
// vpsc_store
// Slot value and count memories plus the per-site fill count memory.
// ----------------------------------------------------------------------------
module vpsc_store #(
	parameter int unsigned SITES          = vpsc_pkg::DefSites,
	parameter int unsigned SLOTS_PER_SITE = vpsc_pkg::DefSlotsPerSite,
	localparam int unsigned Entries = SITES * SLOTS_PER_SITE,
	localparam int unsigned EntW  = (Entries > 1) ? $clog2(Entries) : 1,
	localparam int unsigned SiteW = (SITES > 1) ? $clog2(SITES) : 1,
	localparam int unsigned KW    = $clog2(SLOTS_PER_SITE + 1)
) (
	input  logic                 clk,
	input  vpsc_pkg::store_we_t  we,
	input  logic [EntW-1:0]      slot_addr,
	input  logic [63:0]          wr_value,
	input  logic [63:0]          wr_count,
	output logic [63:0]          rd_value,
	output logic [63:0]          rd_count,
	input  logic [SiteW-1:0]     fill_addr,
	input  logic [KW-1:0]        fill_wdata,
	output logic [KW-1:0]        fill_rdata
);
	import vpsc_pkg::*;

	logic [63:0]   value_mem [Entries];
	logic [63:0]   count_mem [Entries];
	logic [KW-1:0] fill_mem  [SITES];

	// slot value memory
	always_ff @(posedge clk) begin
		if (we.val_we) begin
			value_mem[slot_addr] <= wr_value;
		end
		rd_value <= value_mem[slot_addr];
	end

	// slot count memory
	always_ff @(posedge clk) begin
		if (we.cnt_we) begin
			count_mem[slot_addr] <= wr_count;
		end
		rd_count <= count_mem[slot_addr];
	end

	// per-site fill count
	always_ff @(posedge clk) begin
		if (we.fill_we) begin
			fill_mem[fill_addr] <= fill_wdata;
		end
		fill_rdata <= fill_mem[fill_addr];
	end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the value profile site counter.
// ----------------------------------------------------------------------------
// Drives input beats of every opcode through plain, range and memop mapping,
// keeps a private copy of the slot tables and pool fill, and compares every
// output beat field by field against the oldest predicted beat. Sender gaps
// and receiver stalls vary by phase; one phase holds the output for a long
// stretch so the block backs up, and one phase spreads beats over many sites.
// ----------------------------------------------------------------------------
module testbench;
	import vpsc_pkg::*;

	localparam int unsigned NSites   = DefSites;
	localparam int unsigned NSlots   = DefSlotsPerSite;
	localparam int unsigned NPool    = DefPoolNodes;
	localparam longint      CycleCap = 3000000;

	typedef struct packed {
		logic [2:0]  st;
		logic [63:0] val;
		logic [63:0] cnt;
	} profile_beat_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic [9:0]         site;
	logic               has_value_table;
	logic [63:0]        obs_value;
	logic signed [63:0] range_start;
	logic signed [63:0] range_last;
	logic signed [63:0] large_threshold;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic [63:0]        recorded_value;
	logic [63:0]        entry_count;

	// predictor copy of the slot store
	logic [63:0]     pred_value [NSites*NSlots];
	logic [63:0]     pred_count [NSites*NSlots];
	bit              pred_valid [NSites*NSlots];
	int unsigned     pred_pool;
	profile_beat_t   pending_beats [$];
	int              err_count;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              hold_reqs;
	int              hold_done;
	int              hold_cycles;
	longint          cycle_no = 0;

	value_profile_site_counter u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.site            (site),
		.has_value_table (has_value_table),
		.obs_value       (obs_value),
		.range_start     (range_start),
		.range_last      (range_last),
		.large_threshold (large_threshold),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.recorded_value  (recorded_value),
		.entry_count     (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// map the observed value by opcode
	function automatic logic [63:0] map_value(logic [1:0] op, logic [63:0] v,
			logic signed [63:0] lo, logic signed [63:0] hi, logic signed [63:0] big);
		logic [63:0] top;
		if (op == OP_RANGE) begin
			if (big != SignMin && $signed(v) >= big)
				return big;
			if ($signed(v) < lo || $signed(v) > hi)
				return hi + 64'd1;
			return v;
		end
		if (op == OP_MEMOP) begin
			if (v <= MemopSmall)
				return v;
			if (v >= MemopLast)
				return MemopLast;
			if ((v & (v - 64'd1)) == 64'd0)
				return v;
			top = 64'd1;
			while ((top << 1) <= v)
				top = top << 1;
			return top + 64'd1;
		end
		return v;
	endfunction

	// update the predicted slot store and return the expected beat
	function automatic profile_beat_t profile_update(logic [1:0] op, logic [9:0] s,
			logic tbl, logic [63:0] v, logic signed [63:0] lo,
			logic signed [63:0] hi, logic signed [63:0] big);
		profile_beat_t r;
		int unsigned base, used, min_idx, e;
		logic [63:0] min_cnt;
		bit hit;
		r.val = map_value(op, v, lo, hi, big);
		r.cnt = 64'd0;
		if (!tbl || s >= NSites) begin
			r.st = ST_IGNORED;
			return r;
		end
		base = s * NSlots;
		used = 0;
		min_idx = base;
		min_cnt = '1;
		hit = 0;
		for (int k = 0; k < NSlots; k++) begin
			e = base + k;
			if (!pred_valid[e])
				break;
			if (pred_value[e] == r.val) begin
				pred_count[e] = pred_count[e] + 64'd1;
				r.cnt = pred_count[e];
				hit = 1;
				break;
			end
			if (pred_count[e] < min_cnt) begin
				min_cnt = pred_count[e];
				min_idx = e;
			end
			used++;
		end
		if (hit) begin
			r.st = ST_HIT;
		end else if (used >= NSlots) begin
			if (pred_count[min_idx] != 0)
				pred_count[min_idx] = pred_count[min_idx] - 64'd1;
			if (pred_count[min_idx] == 0) begin
				pred_value[min_idx] = r.val;
				pred_count[min_idx] = 64'd1;
				r.st = ST_REPLACED;
			end else begin
				r.st = ST_DECR;
			end
			r.cnt = pred_count[min_idx];
		end else if (pred_pool >= NPool - 1) begin
			r.st = ST_POOLFULL;
		end else begin
			e = base + used;
			pred_pool++;
			pred_valid[e] = 1;
			pred_value[e] = r.val;
			pred_count[e] = 64'd1;
			r.cnt = 64'd1;
			r.st = ST_NEW;
		end
		return r;
	endfunction

	// offer one beat, hold it until accepted, then predict its result
	task automatic send_beat(logic [1:0] op, logic [9:0] s, logic tbl, logic [63:0] v,
			logic [63:0] lo, logic [63:0] hi, logic [63:0] big);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		opcode          <= op;
		site            <= s;
		has_value_table <= tbl;
		obs_value       <= v;
		range_start     <= lo;
		range_last      <= hi;
		large_threshold <= big;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_beats.push_back(profile_update(op, s, tbl, v, lo, hi, big));
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		drop_valid();
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	// random 64-bit value biased toward small and boundary values
	function automatic logic [63:0] rand_value();
		case ($urandom_range(5))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(12));
			2: return 64'($urandom_range(600));
			3: return 64'd1 << $urandom_range(63);
			4: return {1'b1, 63'($urandom_range(3))} ^ 64'($urandom_range(1) << 63);
			default: return 64'($urandom_range(30)) - 64'd15;
		endcase
	endfunction

	task automatic send_random(int unsigned site_hi, int unsigned pool_len);
		logic [63:0] a, b, v;
		logic [63:0] big;
		a = 64'($urandom_range(40)) - 64'd20;
		b = a + 64'($urandom_range(20));
		if ($urandom_range(9) == 0) begin
			a = {$urandom, $urandom};
			b = {$urandom, $urandom};
		end
		big = ($urandom_range(2) == 0) ? SignMin :
			(($urandom_range(1) == 0) ? b + 64'($urandom_range(5)) : {$urandom, $urandom});
		v = ($urandom_range(3) == 0) ? rand_value() : 64'($urandom_range(pool_len));
		send_beat(2'($urandom_range(3)), 10'($urandom_range(site_hi)),
			$urandom_range(15) != 0, v, a, b, big);
	endtask

	// directed: field extremes, every opcode and the named corner cases
	task automatic test_directed();
		send_beat(OP_PLAIN, 10'd0, 1'b1, 64'd0, 64'd0, 64'd0, SignMin);
		send_beat(OP_PLAIN, 10'd0, 1'b1, 64'd0, 64'd0, 64'd0, SignMin);
		send_beat(OP_PLAIN, 10'd1023, 1'b1, '1, '1, '1, '1);
		send_beat(2'd3, 10'd1023, 1'b1, '1, 64'd0, 64'd0, SignMin);
		send_beat(OP_PLAIN, 10'd5, 1'b0, 64'd7, 64'd0, 64'd0, SignMin);
		send_beat(OP_RANGE, 10'd2, 1'b1, 64'd100, 64'd0, 64'd9, 64'd50);
		send_beat(OP_RANGE, 10'd2, 1'b1, 64'd5, 64'd0, 64'd9, SignMin);
		send_beat(OP_RANGE, 10'd2, 1'b1, '1, 64'd0, 64'd9, SignMin);
		send_beat(OP_RANGE, 10'd2, 1'b1, 64'd3, 64'd0, 64'h7fff_ffff_ffff_ffff, SignMin);
		send_beat(OP_RANGE, 10'd2, 1'b1, SignMin, SignMin, 64'd0, 64'h7fff_ffff_ffff_ffff);
		send_beat(OP_MEMOP, 10'd3, 1'b1, 64'd8, 64'd0, 64'd0, SignMin);
		send_beat(OP_MEMOP, 10'd3, 1'b1, 64'd9, 64'd0, 64'd0, SignMin);
		send_beat(OP_MEMOP, 10'd3, 1'b1, 64'd256, 64'd0, 64'd0, SignMin);
		send_beat(OP_MEMOP, 10'd3, 1'b1, 64'd511, 64'd0, 64'd0, SignMin);
		send_beat(OP_MEMOP, 10'd3, 1'b1, 64'd512, 64'd0, 64'd0, SignMin);
		send_beat(OP_MEMOP, 10'd3, 1'b1, 64'd513, 64'd0, 64'd0, SignMin);
		send_beat(OP_MEMOP, 10'd3, 1'b1, '1, 64'd0, 64'd0, SignMin);
		// fill one site, then evict and replace
		for (int k = 0; k < NSlots + 3; k++)
			send_beat(OP_PLAIN, 10'd4, 1'b1, 64'(k), 64'd0, 64'd0, SignMin);
		wait_drained();
	endtask

	// random mix over a few sites so slots fill up and evict
	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++)
			send_random(15, 12);
		wait_drained();
	endtask

	// hold the output long enough for the block to back up its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_reqs++;
		for (int i = 0; i < 40; i++)
			send_random(15, 12);
		wait_drained();
	endtask

	// spread beats over many sites
	task automatic test_site_spread();
		send_idle_pct = 0;
		recv_stall_pct = 10;
		for (int s = 0; s < 32; s++)
			send_beat(OP_PLAIN, 10'(s * 32 + 7), 1'b1, 64'(s) + 64'd1000, 64'd0, 64'd0,
				SignMin);
		for (int i = 0; i < 40; i++)
			send_random(1023, 2000);
		wait_drained();
	endtask

	// receiver stall and long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall   <= 1'b0;
			hold_cycles <= 0;
			hold_done   <= 0;
		end else if (hold_reqs != hold_done) begin
			out_stall   <= 1'b1;
			hold_cycles <= 400;
			hold_done   <= hold_reqs;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// compare each output beat with the oldest prediction
	always @(posedge clk) begin
		profile_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat status=%0d value=%h count=%h",
					$time, status, recorded_value, entry_count);
				err_count++;
			end else begin
				want = pending_beats.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					err_count++;
				end
				if (recorded_value !== want.val) begin
					$display("%0t: recorded_value expected %h actual %h",
						$time, want.val, recorded_value);
					err_count++;
				end
				if (entry_count !== want.cnt) begin
					$display("%0t: entry_count expected %h actual %h",
						$time, want.cnt, entry_count);
					err_count++;
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no > CycleCap) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = '0;
		site = '0;
		has_value_table = 1'b0;
		obs_value = '0;
		range_start = '0;
		range_last = '0;
		large_threshold = '0;
		err_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_reqs = 0;
		pred_pool = 0;
		for (int i = 0; i < NSites * NSlots; i++) begin
			pred_value[i] = '0;
			pred_count[i] = '0;
			pred_valid[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 0, 0);
		test_random(250, 60, 0);
		test_random(250, 0, 60);
		test_random(250, 27, 27);
		test_backpressure();
		test_random(400, 10, 10);
		test_site_spread();
		repeat (60) @(posedge clk);
		if (err_count == 0 && pending_beats.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[value_profile_site_counter.f]
src/vpsc_pkg.sv
src/vpsc_mapper.sv
src/vpsc_store.sv
src/value_profile_site_counter.sv
tb/sv/testbench.sv
